/* src/lbeh_pkg.sv */
// lbeh_pkg: shared constants, types and the bin edge table for the
// log-binned energy histogram. No dependencies.
`default_nettype none

package lbeh_pkg;

    localparam int BIN_COUNT   = 64;
    localparam int BIN_BITS    = $clog2(BIN_COUNT);
    localparam int ENERGY_BITS = 24;
    localparam int COUNT_BITS  = 32;

    localparam int  EDGE_LOW_EV    = 1000;
    localparam int  SPAN_RATIO     = 15000;
    localparam real BIN_STEP       = 1.0 / BIN_COUNT;
    localparam int  EDGE_WIDE_BITS = ENERGY_BITS * (BIN_COUNT + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic {
        MODE_RECORD = 1'b0,
        MODE_READ   = 1'b1
    } mode_t;

    typedef logic [ENERGY_BITS-1:0] edge_tab_t [BIN_COUNT];

    typedef struct packed {
        logic [COUNT_BITS-1:0] primary;
        logic [COUNT_BITS-1:0] total;
    } count_pair_t;

    typedef struct packed {
        logic                en;
        logic [BIN_BITS-1:0] addr;
        count_pair_t         data;
    } wr_req_t;

    // e raised to BIN_COUNT, exact
    function automatic logic [EDGE_WIDE_BITS-1:0] edge_power(input logic [ENERGY_BITS-1:0] e);
        logic [EDGE_WIDE_BITS-1:0] acc;
        logic [EDGE_WIDE_BITS-1:0] base;
        acc  = EDGE_WIDE_BITS'(1);
        base = EDGE_WIDE_BITS'(e);
        for (int j = 0; j <= BIN_BITS; j++)
        begin
            if (BIN_COUNT[j])
            begin
                acc = acc * base;
            end
            base = base * base;
        end
        return acc;
    endfunction

    // rough starting point for the exact search
    function automatic logic [ENERGY_BITS-1:0] edge_estimate(input int k);
        real x;
        x = real'(EDGE_LOW_EV) * (real'(SPAN_RATIO) ** (real'(k) * BIN_STEP));
        return ENERGY_BITS'($rtoi(x));
    endfunction

    // threshold k: least E with E^BIN_COUNT >= 1000^BIN_COUNT * ratio^k,
    // worked out at elaboration
    function automatic edge_tab_t build_edges();
        edge_tab_t                 tab;
        logic [EDGE_WIDE_BITS-1:0] rhs;
        logic [ENERGY_BITS-1:0]    e;
        rhs = EDGE_WIDE_BITS'(1);
        for (int j = 0; j < BIN_COUNT; j++)
        begin
            rhs = rhs * EDGE_WIDE_BITS'(EDGE_LOW_EV);
        end
        tab[0] = ENERGY_BITS'(EDGE_LOW_EV);
        for (int k = 1; k < BIN_COUNT; k++)
        begin
            rhs = rhs * EDGE_WIDE_BITS'(SPAN_RATIO);
            e   = edge_estimate(k);
            while (edge_power(e) < rhs)
            begin
                e = e + 1'b1;
            end
            while (edge_power(e - 1'b1) >= rhs)
            begin
                e = e - 1'b1;
            end
            tab[k] = e;
        end
        return tab;
    endfunction

    localparam edge_tab_t EDGE_TABLE = build_edges();

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    endfunction

endpackage

`default_nettype wire

/* src/lbeh_count_store.sv */
// lbeh_count_store: primary and total bin counters in one synchronous memory
// pair, registered read, per-bin valid bits cleared at reset.
// Depends on lbeh_pkg.
`default_nettype none

module lbeh_count_store
    import lbeh_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rd_en,
    input  wire logic [BIN_BITS-1:0] rd_addr,
    input  wire wr_req_t             wr,
    output count_pair_t              rd
);

    logic [COUNT_BITS-1:0] primary_mem [BIN_COUNT];
    logic [COUNT_BITS-1:0] total_mem   [BIN_COUNT];
    logic [BIN_COUNT-1:0]  valid_reg;
    count_pair_t           rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            primary_mem[wr.addr] <= wr.data.primary;
            total_mem[wr.addr]   <= wr.data.total;
        end
        if (rd_en)
        begin
            rd_data_reg.primary <= primary_mem[rd_addr];
            rd_data_reg.total   <= total_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written bins read as zero
    assign rd = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

/* src/log_binned_energy_histogram_unit.sv */
// log_binned_energy_histogram_unit: top level of the log-binned photon energy
// histogram, bin search pipeline with read-modify-write of the counters.
// Depends on lbeh_pkg and lbeh_count_store.
//
// Usage:
//   A request enters on in_valid/in_ready with mode, is_primary, energy_ev and
//   bin_select. Record mode finds the bin of energy_ev against the edge table
//   and bumps the total count (and the primary count for primary photons),
//   returning the bin and both counts after the update. Read mode returns both
//   counts of bin_select. A zero energy in record mode returns an all-zero result.
//   Results leave on out_valid/out_ready, one per request, in order.
//   Each request is registered at acceptance after the threshold compare, then
//   passes the bin encode with counter memory read, then update and
//   write-back into the output register, where out_valid rises.
//   Throughput is one request per cycle while the receiver takes results;
//   back-to-back hits on one bin are served by forwarding the last write-back.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_ready drops until the output register is taken.
//   Reset clears all counts to zero at once through per-bin valid bits; the
//   block takes requests from the first cycle after reset.
`default_nettype none

module log_binned_energy_histogram_unit
    import lbeh_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   mode,
    input  wire logic                   is_primary,
    input  wire logic [ENERGY_BITS-1:0] energy_ev,
    input  wire logic [BIN_BITS-1:0]    bin_select,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [BIN_BITS-1:0]         bin_number,
    output logic                        counted,
    output logic [COUNT_BITS-1:0]       primary_count,
    output logic [COUNT_BITS-1:0]       total_count
);

    logic advance;

    // stage 1: threshold compare
    logic                  s1_valid_reg, s1_valid_next;
    mode_t                 s1_mode_reg;
    logic                  s1_primary_reg;
    logic                  s1_zero_reg;
    logic [BIN_BITS-1:0]   s1_sel_reg;
    logic [BIN_COUNT-1:1]  s1_therm_reg, s1_therm_next;

    // stage 2: counter read
    logic                  s2_valid_reg;
    mode_t                 s2_mode_reg;
    logic                  s2_primary_reg;
    logic                  s2_zero_reg;
    logic [BIN_BITS-1:0]   s2_bin_reg;
    logic [BIN_BITS-1:0]   s1_bin;
    logic [BIN_BITS-1:0]   s1_addr;

    // forwarding of the last write-back
    logic                  wb_valid_reg;
    logic [BIN_BITS-1:0]   wb_addr_reg;
    count_pair_t           wb_data_reg;

    count_pair_t           rd_data;
    count_pair_t           cur;
    count_pair_t           upd;
    wr_req_t               wr;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [BIN_BITS-1:0]   out_bin_reg, out_bin_next;
    logic                  out_counted_reg, out_counted_next;
    count_pair_t           out_counts_reg, out_counts_next;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        s1_valid_next = in_valid;
        for (int k = 1; k < BIN_COUNT; k++)
        begin
            s1_therm_next[k] = (energy_ev >= EDGE_TABLE[k]);
        end
    end

    always_comb
    begin
        s1_bin = '0;
        for (int k = 1; k < BIN_COUNT; k++)
        begin
            if (s1_therm_reg[k])
            begin
                s1_bin = k[BIN_BITS-1:0];
            end
        end
        s1_addr = (s1_mode_reg == MODE_READ) ? s1_sel_reg : s1_bin;
    end

    lbeh_count_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (advance && s1_valid_reg),
        .rd_addr (s1_addr),
        .wr      (wr),
        .rd      (rd_data)
    );

    always_comb
    begin
        if (wb_valid_reg && (wb_addr_reg == s2_bin_reg))
        begin
            cur = wb_data_reg;
        end
        else
        begin
            cur = rd_data;
        end
        upd.total   = sat_inc(cur.total);
        upd.primary = s2_primary_reg ? sat_inc(cur.primary) : cur.primary;

        wr.en   = advance && s2_valid_reg && (s2_mode_reg == MODE_RECORD) && !s2_zero_reg;
        wr.addr = s2_bin_reg;
        wr.data = upd;
    end

    always_comb
    begin
        out_valid_next   = s2_valid_reg;
        out_bin_next     = '0;
        out_counted_next = 1'b0;
        out_counts_next  = '0;
        case (s2_mode_reg)
            MODE_READ:
            begin
                out_bin_next    = s2_bin_reg;
                out_counts_next = cur;
            end
            MODE_RECORD:
            begin
                if (!s2_zero_reg)
                begin
                    out_bin_next     = s2_bin_reg;
                    out_counted_next = 1'b1;
                    out_counts_next  = upd;
                end
            end
            default:
            begin
                out_counts_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wb_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s1_valid_reg  <= s1_valid_next;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= out_valid_next;
            end
            if (wr.en)
            begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_mode_reg     <= mode_t'(mode);
            s1_primary_reg  <= is_primary;
            s1_zero_reg     <= (energy_ev == '0);
            s1_sel_reg      <= bin_select;
            s1_therm_reg    <= s1_therm_next;

            s2_mode_reg     <= s1_mode_reg;
            s2_primary_reg  <= s1_primary_reg;
            s2_zero_reg     <= s1_zero_reg;
            s2_bin_reg      <= s1_addr;

            out_bin_reg     <= out_bin_next;
            out_counted_reg <= out_counted_next;
            out_counts_reg  <= out_counts_next;
        end
        if (wr.en)
        begin
            wb_addr_reg <= wr.addr;
            wb_data_reg <= wr.data;
        end
    end

    assign out_valid     = out_valid_reg;
    assign bin_number    = out_bin_reg;
    assign counted       = out_counted_reg;
    assign primary_count = out_counts_reg.primary;
    assign total_count   = out_counts_reg.total;

endmodule

`default_nettype wire

/* bench/log_binned_energy_histogram_unit_test.sv */
// log_binned_energy_histogram_unit_test: self-checking bench for the log-binned
// photon energy histogram, exact edge thresholds and in-order result checking.
// Depends on lbeh_pkg and log_binned_energy_histogram_unit.
`timescale 1ns / 100ps

module log_binned_energy_histogram_unit_test;

    import lbeh_pkg::*;

    localparam int WIDE_BITS   = 1600;
    localparam int STALL_LIMIT = 4000;
    localparam logic [ENERGY_BITS-1:0] ENERGY_TOP = '1;

    typedef struct packed {
        logic [BIN_BITS-1:0]   bin_idx;
        logic                  counted;
        logic [COUNT_BITS-1:0] prim;
        logic [COUNT_BITS-1:0] total;
    } bin_outcome_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   mode;
    logic                   is_primary;
    logic [ENERGY_BITS-1:0] energy_ev;
    logic [BIN_BITS-1:0]    bin_select;
    logic                   out_valid;
    logic                   out_ready;
    logic [BIN_BITS-1:0]    bin_number;
    logic                   counted;
    logic [COUNT_BITS-1:0]  primary_count;
    logic [COUNT_BITS-1:0]  total_count;

    logic [ENERGY_BITS-1:0] threshold_ev [BIN_COUNT];
    logic [COUNT_BITS-1:0]  primary_tally [BIN_COUNT];
    logic [COUNT_BITS-1:0]  total_tally [BIN_COUNT];
    bin_outcome_t           expected_counts [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int quiet_cycles;
    logic [ENERGY_BITS-1:0] last_energy;

    log_binned_energy_histogram_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .is_primary    (is_primary),
        .energy_ev     (energy_ev),
        .bin_select    (bin_select),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .bin_number    (bin_number),
        .counted       (counted),
        .primary_count (primary_count),
        .total_count   (total_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [WIDE_BITS-1:0] pow_bins(input logic [31:0] e);
        logic [WIDE_BITS-1:0] p;
        p = WIDE_BITS'(e);
        repeat (6)
        begin
            p = p * p;
        end
        return p;
    endfunction

    function automatic int energy_bin(input logic [ENERGY_BITS-1:0] e);
        int b;
        b = 0;
        for (int k = 1; k < BIN_COUNT; k++)
        begin
            if (e >= threshold_ev[k])
            begin
                b = k;
            end
        end
        return b;
    endfunction

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic bin_outcome_t tally_request(input logic m, input logic prim,
                                                   input logic [ENERGY_BITS-1:0] e,
                                                   input logic [BIN_BITS-1:0] sel);
        bin_outcome_t r;
        int b;
        r = '0;
        if (m == MODE_READ)
        begin
            r.bin_idx = sel;
            r.prim    = primary_tally[sel];
            r.total   = total_tally[sel];
        end
        else if (e != 0)
        begin
            b = energy_bin(e);
            total_tally[b] = bump(total_tally[b]);
            if (prim)
            begin
                primary_tally[b] = bump(primary_tally[b]);
            end
            r.bin_idx = BIN_BITS'(b);
            r.counted = 1'b1;
            r.prim    = primary_tally[b];
            r.total   = total_tally[b];
        end
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [COUNT_BITS-1:0] want,
                                 input logic [COUNT_BITS-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
            end
        end
    endtask

    // request and result monitor, prediction at acceptance, watchdog
    always @(posedge clk)
    begin : monitor
        bin_outcome_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_counts = {expected_counts,
                                   tally_request(mode, is_primary, energy_ev, bin_select)};
            end
            if (out_valid && out_ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result with no request outstanding: bin %0d", bin_number);
                    end
                end
                else
                begin
                    want = expected_counts.pop_front();
                    compare_field("bin_number", COUNT_BITS'(want.bin_idx),
                                  COUNT_BITS'(bin_number));
                    compare_field("counted", COUNT_BITS'(want.counted), COUNT_BITS'(counted));
                    compare_field("primary_count", want.prim, primary_count);
                    compare_field("total_count", want.total, total_count);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("log_binned_energy_histogram_unit verification failed");
                    $finish;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(input logic m, input logic prim,
                                input logic [ENERGY_BITS-1:0] e,
                                input logic [BIN_BITS-1:0] sel);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        is_primary <= prim;
        energy_ev  <= e;
        bin_select <= sel;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_counts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_zero_energy();
        send_request(MODE_RECORD, 1'b1, '0, 6'd63);
        send_request(MODE_RECORD, 1'b0, '0, 6'd0);
    endtask

    task automatic test_range_ends();
        send_request(MODE_RECORD, 1'b1, 24'd1, 6'd0);
        send_request(MODE_RECORD, 1'b0, 24'd999, 6'd0);
        send_request(MODE_RECORD, 1'b1, 24'd1000, 6'd0);
        send_request(MODE_RECORD, 1'b0, threshold_ev[1] - 1'b1, 6'd0);
        send_request(MODE_RECORD, 1'b1, threshold_ev[1], 6'd0);
        send_request(MODE_RECORD, 1'b0, threshold_ev[BIN_COUNT-1] - 1'b1, 6'd0);
        send_request(MODE_RECORD, 1'b1, threshold_ev[BIN_COUNT-1], 6'd0);
        send_request(MODE_RECORD, 1'b0, 24'd14999999, 6'd0);
        send_request(MODE_RECORD, 1'b1, 24'd15000000, 6'd0);
        send_request(MODE_RECORD, 1'b1, ENERGY_TOP, 6'd0);
    endtask

    task automatic test_read_mode();
        send_request(MODE_READ, 1'b1, ENERGY_TOP, 6'd0);
        send_request(MODE_READ, 1'b0, 24'd5000, 6'd63);
        send_request(MODE_READ, 1'b1, '0, 6'd1);
    endtask

    // back-to-back hits on one bin, then an immediate read of it
    task automatic test_same_bin_streak();
        for (int i = 0; i < 6; i++)
        begin
            send_request(MODE_RECORD, i[0], 24'd5000, 6'd0);
        end
        send_request(MODE_READ, 1'b0, '0, BIN_BITS'(energy_bin(24'd5000)));
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct, input bit pause_midway);
        int kind;
        int k;
        logic m;
        logic [ENERGY_BITS-1:0] e;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
            begin
                drain_results();
            end
            kind = $urandom_range(99);
            k    = $urandom_range(BIN_COUNT - 1);
            m    = MODE_RECORD;
            e    = ENERGY_BITS'($urandom_range(ENERGY_TOP, 1));
            if (kind < 15)
            begin
                m = MODE_READ;
                e = ENERGY_BITS'($urandom_range(ENERGY_TOP));
            end
            else if (kind < 20)
            begin
                e = '0;
            end
            else if (kind < 45)
            begin
                e = ENERGY_BITS'(threshold_ev[k] + $urandom_range(2) - 1);
            end
            else if (kind < 60)
            begin
                e = last_energy;
            end
            else if (kind < 70)
            begin
                e = ENERGY_BITS'($urandom_range(999, 1));
            end
            else if (kind < 75)
            begin
                e = ENERGY_BITS'($urandom_range(ENERGY_TOP, 15000000));
            end
            if (m == MODE_RECORD && e != 0)
            begin
                last_energy = e;
            end
            send_request(m, 1'($urandom_range(1)), e, BIN_BITS'($urandom_range(BIN_COUNT - 1)));
        end
    endtask

    initial
    begin : main
        logic [WIDE_BITS-1:0] rhs;
        logic [31:0] c;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = MODE_RECORD;
        is_primary     = 1'b0;
        energy_ev      = '0;
        bin_select     = '0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        last_energy    = 24'd5000;

        // least integer E with E^64 >= 1000^64 * 15000^k
        rhs = WIDE_BITS'(1);
        repeat (BIN_COUNT)
        begin
            rhs = rhs * 1000;
        end
        threshold_ev[0] = 24'd1000;
        for (int k = 1; k < BIN_COUNT; k++)
        begin
            rhs = rhs * 15000;
            c = $rtoi($ceil(1000.0 * (15000.0 ** (real'(k) / real'(BIN_COUNT)))));
            while (pow_bins(c) < rhs)
            begin
                c = c + 1;
            end
            while (c > 1 && pow_bins(c - 1) >= rhs)
            begin
                c = c - 1;
            end
            threshold_ev[k] = c[ENERGY_BITS-1:0];
        end
        for (int k = 0; k < BIN_COUNT; k++)
        begin
            primary_tally[k] = '0;
            total_tally[k]   = '0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_energy();
        test_range_ends();
        test_read_mode();
        test_same_bin_streak();
        test_random_traffic(450, 0, 0, 1'b0);
        test_random_traffic(450, 53, 0, 1'b0);
        test_random_traffic(450, 0, 53, 1'b1);
        test_random_traffic(450, 22, 22, 1'b0);

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_counts.size() == 0)
        begin
            $display("log_binned_energy_histogram_unit verification clean");
        end
        else
        begin
            $display("log_binned_energy_histogram_unit verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
src/lbeh_pkg.sv
src/lbeh_count_store.sv
src/log_binned_energy_histogram_unit.sv
bench/log_binned_energy_histogram_unit_test.sv
